### sv/dssm_pkg.sv
// Shared constants and controller/datapath interface types for the dual stack block.
package dssm_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W    = 32;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP     = 2'd1;
	localparam logic [1:0] OP_DISPLAY = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic       push;       // write word, bump count
		logic       pop;        // read top word, drop count
		logic       walk_start; // read first element of a display
		logic       walk_next;  // read next element of a display
		logic       load;       // load result status
		logic [1:0] code;
		logic       from_mem;   // result data comes from the read register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic sel_empty;
		logic last;
	} stat_t;

endpackage

### sv/dssm_dp.sv
// Datapath: shared word memory, stack fill counters, display index and result registers.
module dssm_dp #(
	parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         stack_sel,
	input  logic signed [31:0]           push_value,
	input  dssm_pkg::cmd_t               cmd,
	output dssm_pkg::stat_t              stat,
	output logic [1:0]                   status,
	output logic signed [31:0]           data_out,
	output logic                         last
);
	import dssm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [CW-1:0]     lower_q, upper_q;
	logic [AW-1:0]     walk_idx_q;
	logic              walk_sel_q;
	logic [WORD_W-1:0] rd_data_q;
	logic [1:0]        status_q;
	logic              last_q;
	logic              from_mem_q;

	logic [CW:0]       fill_sum;
	logic [CW-1:0]     sel_fill, walk_fill;
	logic [AW-1:0]     wr_addr, pop_addr, walk_addr, rd_addr, next_idx;
	logic [CW-1:0]     lower_dec, upper_pop;
	logic              next_sel, rd_en, walking;

	assign fill_sum  = {1'b0, lower_q} + {1'b0, upper_q};
	assign sel_fill  = stack_sel ? upper_q : lower_q;

	assign stat.full      = (fill_sum >= (CW+1)'(DEPTH));
	assign stat.sel_empty = (sel_fill == '0);
	assign stat.last      = last_q;

	// push goes to the next free entry; upper stack counts down from the top
	assign wr_addr   = stack_sel ? (AW'(DEPTH - 1) - upper_q[AW-1:0]) : lower_q[AW-1:0];
	assign lower_dec = lower_q - 1'b1;
	assign upper_pop = CW'(DEPTH) - upper_q;
	assign pop_addr  = stack_sel ? upper_pop[AW-1:0] : lower_dec[AW-1:0];

	assign walking   = cmd.walk_start | cmd.walk_next;
	assign next_idx  = cmd.walk_start ? '0 : walk_idx_q + 1'b1;
	assign next_sel  = cmd.walk_start ? stack_sel : walk_sel_q;
	assign walk_addr = next_sel ? (AW'(DEPTH - 1) - next_idx) : next_idx;
	assign walk_fill = next_sel ? upper_q : lower_q;

	assign rd_en   = cmd.pop | walking;
	assign rd_addr = cmd.pop ? pop_addr : walk_addr;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (cmd.push) begin
			if (stack_sel) upper_q <= upper_q + 1'b1;
			else           lower_q <= lower_q + 1'b1;
		end else if (cmd.pop) begin
			if (stack_sel) upper_q <= upper_q - 1'b1;
			else           lower_q <= lower_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (walking) begin
			walk_idx_q <= next_idx;
			walk_sel_q <= next_sel;
		end
		if (cmd.load) begin
			status_q   <= cmd.code;
			from_mem_q <= cmd.from_mem;
		end
		if (cmd.load || cmd.walk_next) begin
			last_q <= walking ? ((CW'(next_idx) + 1'b1) == walk_fill) : 1'b1;
		end
	end

	assign status   = status_q;
	assign data_out = from_mem_q ? rd_data_q : '0;
	assign last     = last_q;

endmodule

### sv/dssm_ctrl.sv
// Controller: decodes transactions and sequences result delivery and display walks.
module dssm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       op,
	input  logic             out_ready,
	input  dssm_pkg::stat_t  stat,
	output logic             in_ready,
	output logic             out_valid,
	output dssm_pkg::cmd_t   cmd
);
	import dssm_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_OUT  = 1'b1;

	logic state_q, state_d;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						OP_PUSH: begin
							cmd.load = 1'b1;
							cmd.push = !stat.full;
							cmd.code = stat.full ? ST_OVERFLOW : ST_OK;
							state_d  = S_OUT;
						end
						OP_POP: begin
							cmd.load     = 1'b1;
							cmd.pop      = !stat.sel_empty;
							cmd.from_mem = !stat.sel_empty;
							cmd.code     = stat.sel_empty ? ST_UNDERFLOW : ST_OK;
							state_d      = S_OUT;
						end
						OP_DISPLAY: begin
							cmd.load       = 1'b1;
							cmd.walk_start = !stat.sel_empty;
							cmd.from_mem   = !stat.sel_empty;
							cmd.code       = stat.sel_empty ? ST_EMPTY : ST_OK;
							state_d        = S_OUT;
						end
						default: begin
						end
					endcase
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last) state_d = S_IDLE;
					else           cmd.walk_next = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

### sv/dual_stack_shared_memory.sv
// Top level: two LIFO stacks sharing one memory of DEPTH words.
//
// Input channel (in_valid/in_ready): op, stack_sel, push_value. One transaction
// is a push, a pop or a display of the selected stack. Stack 0 grows up from
// entry 0, stack 1 grows down from entry DEPTH-1; pushes fail once the fills meet.
// Output channel (out_valid/out_ready): status, data_out, last. Push and pop give
// one result; a display gives one result per element, bottom first, with last on
// the final one, or one empty result. Op code 3 is dropped with no result.
// Timing: a result is valid the cycle after its input transaction is taken.
// Throughput: a push or pop is accepted, then delivered, before the next is
// taken; a display gives one element per cycle while the receiver is ready,
// limited by the single registered memory read port.
// The block takes one input transaction at a time: in_ready is high only while
// no result is pending. If the receiver stalls, the result register holds and
// the display walk pauses. Reset clears both fill counts and the controller;
// memory contents are not cleared and no clearing pass is needed.
module dual_stack_shared_memory #(
	parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic               stack_sel,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] data_out,
	output logic               last
);
	import dssm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencing: decode, result handshake, display walk stepping
	dssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// memory, fill counters, addressing and result registers
	dssm_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.stack_sel  (stack_sel),
		.push_value (push_value),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status),
		.data_out   (data_out),
		.last       (last)
	);

endmodule
